/* hdl/dsl_pkg.sv */
`default_nettype none

package dsl_pkg;

    localparam int IN_W       = 112;
    localparam int OUT_W      = 88;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PEDAL_RATE_RST        = 16'd8192;
    localparam logic [15:0] STEER_RATE_RST        = 16'd16384;
    localparam logic [15:0] STEER_RETURN_RATE_RST = 16'd32768;
    localparam logic [14:0] MAX_STEER_RST         = 15'd0;
    localparam logic [15:0] STEER_FALLOFF_RST     = 16'd0;

    localparam logic [12:0] LEVEL_ONE  = 13'd4096;
    localparam logic [31:0] DENOM_ONE  = 32'h0100_0000;
    localparam logic [3:0]  DIV_STEPS  = 4'd15;

    typedef enum logic [2:0] {
        REG_PEDAL_RATE        = 3'd0,
        REG_STEER_RATE        = 3'd1,
        REG_STEER_RETURN_RATE = 3'd2,
        REG_MAX_STEER         = 3'd3,
        REG_STEER_FALLOFF     = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PSTEP,
        S_SSTEP,
        S_DENOM,
        S_DIV,
        S_TARGET,
        S_SLEW_T,
        S_SLEW_B,
        S_SLEW_S,
        S_CLAMP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PSTEP,
        OP_SSTEP,
        OP_DENOM,
        OP_DIV,
        OP_TARGET,
        OP_SLEW_T,
        OP_SLEW_B,
        OP_SLEW_S,
        OP_CLAMP
    } t_op;

    typedef struct packed {
        logic load;
        logic emit;
        t_op  op;
    } t_ctl;

    function automatic logic [12:0] clamp_unit(input logic signed [13:0] v);
        logic [12:0] r;
        if (v < 14'sd0) begin
            r = 13'd0;
        end else if (v > 14'sd4096) begin
            r = LEVEL_ONE;
        end else begin
            r = v[12:0];
        end
        return r;
    endfunction

    function automatic logic signed [13:0] clamp_sym(input logic signed [13:0] v);
        logic signed [13:0] r;
        if (v < -14'sd4096) begin
            r = -14'sd4096;
        end else if (v > 14'sd4096) begin
            r = 14'sd4096;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/dsl_seq.sv */
`default_nettype none

module dsl_seq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output dsl_pkg::t_ctl    o_ctl
);

    dsl_pkg::t_state r_state, n_state;
    logic [3:0]      r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dsl_pkg::S_IDLE:   if (i_in_valid) n_state = dsl_pkg::S_PSTEP;
            dsl_pkg::S_PSTEP:  n_state = dsl_pkg::S_SSTEP;
            dsl_pkg::S_SSTEP:  n_state = dsl_pkg::S_DENOM;
            dsl_pkg::S_DENOM:  n_state = dsl_pkg::S_DIV;
            dsl_pkg::S_DIV:    if (r_cnt == dsl_pkg::DIV_STEPS - 4'd1) n_state = dsl_pkg::S_TARGET;
            dsl_pkg::S_TARGET: n_state = dsl_pkg::S_SLEW_T;
            dsl_pkg::S_SLEW_T: n_state = dsl_pkg::S_SLEW_B;
            dsl_pkg::S_SLEW_B: n_state = dsl_pkg::S_SLEW_S;
            dsl_pkg::S_SLEW_S: n_state = dsl_pkg::S_CLAMP;
            dsl_pkg::S_CLAMP:  n_state = dsl_pkg::S_DONE;
            dsl_pkg::S_DONE:   if (out_free) n_state = dsl_pkg::S_IDLE;
            default:           n_state = dsl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_ctl.load   = 1'b0;
        o_ctl.emit   = 1'b0;
        o_ctl.op     = dsl_pkg::OP_NONE;
        n_cnt        = r_cnt;
        case (r_state)
            dsl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            dsl_pkg::S_PSTEP:  o_ctl.op = dsl_pkg::OP_PSTEP;
            dsl_pkg::S_SSTEP:  o_ctl.op = dsl_pkg::OP_SSTEP;
            dsl_pkg::S_DENOM: begin
                o_ctl.op = dsl_pkg::OP_DENOM;
                n_cnt    = 4'd0;
            end
            dsl_pkg::S_DIV: begin
                o_ctl.op = dsl_pkg::OP_DIV;
                n_cnt    = r_cnt + 4'd1;
            end
            dsl_pkg::S_TARGET: o_ctl.op = dsl_pkg::OP_TARGET;
            dsl_pkg::S_SLEW_T: o_ctl.op = dsl_pkg::OP_SLEW_T;
            dsl_pkg::S_SLEW_B: o_ctl.op = dsl_pkg::OP_SLEW_B;
            dsl_pkg::S_SLEW_S: o_ctl.op = dsl_pkg::OP_SLEW_S;
            dsl_pkg::S_CLAMP:  o_ctl.op = dsl_pkg::OP_CLAMP;
            dsl_pkg::S_DONE:   o_ctl.emit = out_free;
            default:           o_ctl.op = dsl_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        if (o_ctl.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsl_pkg::S_IDLE;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/dsl_dp.sv */
`default_nettype none

module dsl_dp #(
    parameter int GEAR_COUNT = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dsl_pkg::t_ctl                     i_ctl,
    input  wire logic [dsl_pkg::IN_W-1:0]          i_in_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [dsl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [dsl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic [dsl_pkg::OUT_W-1:0]              o_out_data
);

    localparam logic [3:0] GEAR_MAX = 4'(GEAR_COUNT - 1);

    logic [15:0] r_pedal_rate, r_steer_rate, r_steer_return_rate, r_steer_falloff;
    logic [14:0] r_max_steer;

    logic [15:0]        r_dt;
    logic [12:0]        r_thr_tgt, r_brk_tgt, r_clutch_out, r_hbk;
    logic [12:0]        r_str_mag;
    logic               r_str_neg;
    logic [15:0]        r_aspd;

    logic [12:0]        r_thr_st, r_brk_st;
    logic signed [15:0] r_steer_st;
    logic [2:0]         r_gear;

    logic [15:0]        r_pstep, r_sstep;
    logic [31:0]        r_denom;
    logic [32:0]        r_rem;
    logic [14:0]        r_quo;
    logic signed [17:0] r_starget;
    logic [dsl_pkg::OUT_W-1:0] r_out;

    logic signed [13:0] in_thr, in_brk, in_str, in_clu, in_hbk, str_c;
    logic signed [15:0] in_spd;
    logic               in_up, in_down, in_restart;
    logic [12:0]        clu_c;
    logic [2:0]         g0, g1, g2;
    logic [3:0]         g_inc;

    logic [15:0]        mul_a, mul_b;
    logic [31:0]        prod;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [14:0]        tgt_mag;

    logic signed [17:0] sl_cur, sl_tgt, sl_diff, sl_res;
    logic [17:0]        sl_mag, sl_step;
    logic signed [15:0] lim_s;

    assign in_thr     = i_in_data[29:16];
    assign in_brk     = i_in_data[43:30];
    assign in_str     = i_in_data[57:44];
    assign in_clu     = i_in_data[71:58];
    assign in_hbk     = i_in_data[85:72];
    assign in_spd     = i_in_data[101:86];
    assign in_up      = i_in_data[102];
    assign in_down    = i_in_data[103];
    assign in_restart = i_in_data[104];
    assign str_c      = dsl_pkg::clamp_sym(in_str);
    assign clu_c      = dsl_pkg::clamp_unit(in_clu);

    always_comb begin
        g0    = in_restart ? 3'd0 : r_gear;
        g_inc = {1'b0, g0} + 4'd1;
        if (in_up) begin
            g1 = (g_inc > GEAR_MAX) ? GEAR_MAX[2:0] : g_inc[2:0];
        end else begin
            g1 = g0;
        end
        if (in_down) begin
            g2 = (g1 == 3'd0) ? 3'd0 : g1 - 3'd1;
        end else begin
            g2 = g1;
        end
    end

    always_comb begin
        case (i_ctl.op)
            dsl_pkg::OP_PSTEP: begin
                mul_a = r_pedal_rate;
                mul_b = r_dt;
            end
            dsl_pkg::OP_SSTEP: begin
                mul_a = (r_str_mag == 13'd0) ? r_steer_return_rate : r_steer_rate;
                mul_b = r_dt;
            end
            dsl_pkg::OP_DENOM: begin
                mul_a = r_steer_falloff;
                mul_b = r_aspd;
            end
            dsl_pkg::OP_TARGET: begin
                mul_a = {3'd0, r_str_mag};
                mul_b = {1'b0, r_quo};
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign tgt_mag = prod[26:12];

    assign rem_sh = {r_rem[31:0], 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_denom};

    always_comb begin
        case (i_ctl.op)
            dsl_pkg::OP_SLEW_T: begin
                sl_cur  = {5'd0, r_thr_st};
                sl_tgt  = {5'd0, r_thr_tgt};
                sl_step = {2'd0, r_pstep};
            end
            dsl_pkg::OP_SLEW_B: begin
                sl_cur  = {5'd0, r_brk_st};
                sl_tgt  = {5'd0, r_brk_tgt};
                sl_step = {2'd0, r_pstep};
            end
            dsl_pkg::OP_SLEW_S: begin
                sl_cur  = {{2{r_steer_st[15]}}, r_steer_st};
                sl_tgt  = r_starget;
                sl_step = {2'd0, r_sstep};
            end
            default: begin
                sl_cur  = 18'sd0;
                sl_tgt  = 18'sd0;
                sl_step = 18'd0;
            end
        endcase
        sl_diff = sl_tgt - sl_cur;
        sl_mag  = (sl_diff < 18'sd0) ? 18'(-sl_diff) : 18'(sl_diff);
        if (sl_mag <= sl_step) begin
            sl_res = sl_tgt;
        end else if (sl_diff > 18'sd0) begin
            sl_res = sl_cur + $signed(sl_step);
        end else begin
            sl_res = sl_cur - $signed(sl_step);
        end
    end

    assign lim_s = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pedal_rate        <= dsl_pkg::PEDAL_RATE_RST;
            r_steer_rate        <= dsl_pkg::STEER_RATE_RST;
            r_steer_return_rate <= dsl_pkg::STEER_RETURN_RATE_RST;
            r_max_steer         <= dsl_pkg::MAX_STEER_RST;
            r_steer_falloff     <= dsl_pkg::STEER_FALLOFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dsl_pkg::REG_PEDAL_RATE:        r_pedal_rate        <= i_cfg_wdata;
                dsl_pkg::REG_STEER_RATE:        r_steer_rate        <= i_cfg_wdata;
                dsl_pkg::REG_STEER_RETURN_RATE: r_steer_return_rate <= i_cfg_wdata;
                dsl_pkg::REG_MAX_STEER:         r_max_steer         <= i_cfg_wdata[14:0];
                dsl_pkg::REG_STEER_FALLOFF:     r_steer_falloff     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_st   <= 13'd0;
            r_brk_st   <= 13'd0;
            r_steer_st <= 16'sd0;
            r_gear     <= 3'd0;
        end else begin
            if (i_ctl.load) begin
                r_gear <= g2;
                if (in_restart) begin
                    r_thr_st   <= 13'd0;
                    r_brk_st   <= 13'd0;
                    r_steer_st <= 16'sd0;
                end
            end
            case (i_ctl.op)
                dsl_pkg::OP_SLEW_T: r_thr_st   <= sl_res[12:0];
                dsl_pkg::OP_SLEW_B: r_brk_st   <= sl_res[12:0];
                dsl_pkg::OP_SLEW_S: r_steer_st <= sl_res[15:0];
                dsl_pkg::OP_CLAMP: begin
                    if (r_steer_st > lim_s) begin
                        r_steer_st <= lim_s;
                    end else if (r_steer_st < -lim_s) begin
                        r_steer_st <= -lim_s;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dt         <= i_in_data[15:0];
            r_thr_tgt    <= dsl_pkg::clamp_unit(in_thr);
            r_brk_tgt    <= dsl_pkg::clamp_unit(in_brk);
            r_hbk        <= dsl_pkg::clamp_unit(in_hbk);
            r_clutch_out <= dsl_pkg::LEVEL_ONE - clu_c;
            r_str_neg    <= str_c < 14'sd0;
            r_str_mag    <= (str_c < 14'sd0) ? 13'(-str_c) : str_c[12:0];
            r_aspd       <= (in_spd < 16'sd0) ? 16'(-in_spd) : in_spd;
        end
        case (i_ctl.op)
            dsl_pkg::OP_PSTEP: r_pstep <= prod[31:16];
            dsl_pkg::OP_SSTEP: r_sstep <= prod[31:16];
            dsl_pkg::OP_DENOM: begin
                r_denom <= dsl_pkg::DENOM_ONE + prod;
                r_rem   <= {9'd0, r_max_steer, 9'd0};
                r_quo   <= 15'd0;
            end
            dsl_pkg::OP_DIV: begin
                r_rem <= rem_ge ? rem_sh - {1'b0, r_denom} : rem_sh;
                r_quo <= {r_quo[13:0], rem_ge};
            end
            dsl_pkg::OP_TARGET: begin
                r_starget <= r_str_neg ? -$signed({3'd0, tgt_mag}) : $signed({3'd0, tgt_mag});
            end
            default: ;
        endcase
        if (i_ctl.emit) begin
            r_out <= {2'd0, r_gear, r_quo, r_steer_st, r_hbk, r_clutch_out, r_brk_st,
                      r_thr_st};
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

/* hdl/driver_input_slew_limiter_unit.sv */
`default_nettype none

// Driver input slew limiter. One item per frame tick; the unit handles one item
// at a time and holds o_s_axis_tready low while it works. An item goes from
// acceptance to its result on the output register through these steps: three
// products on one shared 16x16 multiplier (pedal step, steer step, speed
// falloff), a restoring division for the steering limit, a fourth product for
// the steering target, three passes through one shared slew unit (throttle,
// brake, steering), a limit clamp and the output load. The unit is ready again
// the cycle after the result is loaded. A result still waiting in the output
// register holds the unit only once the next result is ready to load.
// Configuration writes land immediately and must only be made while idle.
// Register reset values: pedal_rate 8192, steer_rate 16384, steer_return_rate
// 32768, max_steer 0, steer_falloff 0.
module driver_input_slew_limiter_unit #(
    parameter int GEAR_COUNT = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // delta_time, raw_throttle, raw_brake, raw_steer, raw_clutch, raw_handbrake,
    // vehicle_speed, shift_up, shift_down, restart
    input  wire logic [dsl_pkg::IN_W-1:0]          i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // throttle_level, brake_level, clutch_engagement, handbrake_level,
    // steer_angle, steer_limit, gear
    output logic [dsl_pkg::OUT_W-1:0]              o_m_axis_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [dsl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [dsl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    dsl_pkg::t_ctl ctl;

    dsl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_ctl       (ctl)
    );

    dsl_dp #(
        .GEAR_COUNT (GEAR_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    logic signed [15:0] a_steer;
    logic signed [15:0] a_limit;
    logic [12:0]        a_throttle;
    logic [2:0]         a_gear;

    assign a_throttle = o_m_axis_tdata[12:0];
    assign a_steer    = o_m_axis_tdata[67:52];
    assign a_limit    = {1'b0, o_m_axis_tdata[82:68]};
    assign a_gear     = o_m_axis_tdata[85:83];

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("unit ready right after taking an item");

    a_steer_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (a_steer <= a_limit && a_steer >= -a_limit))
        else $error("steer angle outside steering limit");

    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({1'b0, a_gear} <= 4'(GEAR_COUNT - 1)))
        else $error("gear beyond top gear");

    a_throttle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (a_throttle <= dsl_pkg::LEVEL_ONE))
        else $error("throttle above full scale");
`endif

endmodule

`default_nettype wire

/* test/driver_input_slew_limiter_unit_tb.sv */
`default_nettype none

module driver_input_slew_limiter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GEAR_COUNT = 5;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic               restart;
        logic               shift_down;
        logic               shift_up;
        logic signed [15:0] vehicle_speed;
        logic signed [13:0] raw_handbrake;
        logic signed [13:0] raw_clutch;
        logic signed [13:0] raw_steer;
        logic signed [13:0] raw_brake;
        logic signed [13:0] raw_throttle;
        logic [15:0]        delta_time;
    } t_tick;

    typedef struct packed {
        logic [2:0]         gear;
        logic [14:0]        steer_limit;
        logic signed [15:0] steer_angle;
        logic [12:0]        handbrake_level;
        logic [12:0]        clutch_engagement;
        logic [12:0]        brake_level;
        logic [12:0]        throttle_level;
    } t_controls;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    t_tick                          drv_tick = '0;
    logic [dsl_pkg::IN_W-1:0]       i_s_axis_tdata;
    logic                           o_m_axis_tvalid;
    logic                           m_tready = 1'b0;
    logic [dsl_pkg::OUT_W-1:0]      o_m_axis_tdata;
    logic                           cfg_we = 1'b0;
    logic [dsl_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [dsl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow registers and state of the predictor
    logic [15:0]        pedal_rate_q = dsl_pkg::PEDAL_RATE_RST;
    logic [15:0]        steer_rate_q = dsl_pkg::STEER_RATE_RST;
    logic [15:0]        return_rate_q = dsl_pkg::STEER_RETURN_RATE_RST;
    logic [14:0]        max_steer_q = dsl_pkg::MAX_STEER_RST;
    logic [15:0]        falloff_q = dsl_pkg::STEER_FALLOFF_RST;
    logic [12:0]        throttle_q = '0;
    logic [12:0]        brake_q = '0;
    logic signed [15:0] steer_q = '0;
    logic [2:0]         gear_q = '0;

    t_tick     pending_ticks[$];
    t_controls expected_controls[$];
    int        err_count = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        jitter_on = 1'b1;

    assign i_s_axis_tdata = {{(dsl_pkg::IN_W - $bits(t_tick)){1'b0}}, drv_tick};

    driver_input_slew_limiter_unit #(
        .GEAR_COUNT(GEAR_COUNT)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int slew_toward(int cur, int goal, int step);
        longint diff;
        diff = longint'(goal) - longint'(cur);
        if ((diff < 0 ? -diff : diff) <= longint'(step)) begin
            return goal;
        end
        return diff > 0 ? cur + step : cur - step;
    endfunction

    function automatic int rate_step(logic [15:0] rate, logic [15:0] dt);
        return int'((longint'(rate) * longint'(dt)) >> 16);
    endfunction

    function automatic t_controls advance_controls(t_tick it);
        int        thr, brk, str, clu, hbk, spd, aspd, lim, goal, abs_str;
        longint    denom, mag;
        t_controls r;
        thr = clip(int'($signed(it.raw_throttle)), 0, 4096);
        brk = clip(int'($signed(it.raw_brake)), 0, 4096);
        str = clip(int'($signed(it.raw_steer)), -4096, 4096);
        clu = clip(int'($signed(it.raw_clutch)), 0, 4096);
        hbk = clip(int'($signed(it.raw_handbrake)), 0, 4096);
        spd = int'($signed(it.vehicle_speed));
        if (it.restart) begin
            throttle_q = '0;
            brake_q = '0;
            steer_q = '0;
            gear_q = '0;
        end
        if (it.shift_up && gear_q < GEAR_COUNT - 1) begin
            gear_q = gear_q + 3'd1;
        end
        if (it.shift_down && gear_q != 3'd0) begin
            gear_q = gear_q - 3'd1;
        end
        throttle_q = 13'(slew_toward(int'(throttle_q), thr,
            rate_step(pedal_rate_q, it.delta_time)));
        brake_q = 13'(slew_toward(int'(brake_q), brk,
            rate_step(pedal_rate_q, it.delta_time)));
        aspd = spd < 0 ? -spd : spd;
        denom = 64'd16777216 + longint'(falloff_q) * longint'(aspd);
        lim = int'((longint'(max_steer_q) << 24) / denom);
        abs_str = str < 0 ? -str : str;
        mag = (longint'(abs_str) * longint'(lim)) >> 12;
        goal = str < 0 ? -int'(mag) : int'(mag);
        steer_q = 16'(clip(slew_toward(int'(steer_q), goal,
            rate_step(str == 0 ? return_rate_q : steer_rate_q, it.delta_time)), -lim, lim));
        r.throttle_level = throttle_q;
        r.brake_level = brake_q;
        r.clutch_engagement = 13'(4096 - clu);
        r.handbrake_level = 13'(hbk);
        r.steer_angle = steer_q;
        r.steer_limit = 15'(lim);
        r.gear = gear_q;
        return r;
    endfunction

    function automatic t_tick make_tick(int dt, int thr, int brk, int str, int clu, int hbk,
                                        int spd, bit up, bit dn, bit rs);
        t_tick it;
        it.delta_time = dt[15:0];
        it.raw_throttle = thr[13:0];
        it.raw_brake = brk[13:0];
        it.raw_steer = str[13:0];
        it.raw_clutch = clu[13:0];
        it.raw_handbrake = hbk[13:0];
        it.vehicle_speed = spd[15:0];
        it.shift_up = up;
        it.shift_down = dn;
        it.restart = rs;
        return it;
    endfunction

    function automatic logic signed [13:0] rand_axis(bit centered);
        int sel;
        int v;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            v = int'($urandom_range(0, 16383)) - 8192;
        end else if (centered && sel < 3) begin
            v = 0;
        end else if (centered) begin
            v = int'($urandom_range(0, 8600)) - 4300;
        end else begin
            v = int'($urandom_range(0, 4400)) - 150;
        end
        return v[13:0];
    endfunction

    function automatic t_tick rand_tick();
        t_tick it;
        int    sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            it.delta_time = 16'($urandom);
        end else if (sel == 1) begin
            it.delta_time = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            it.delta_time = 16'($urandom_range(0, 4096));
        end
        it.raw_throttle = rand_axis(1'b0);
        it.raw_brake = rand_axis(1'b0);
        it.raw_steer = rand_axis(1'b1);
        it.raw_clutch = rand_axis(1'b0);
        it.raw_handbrake = rand_axis(1'b0);
        if ($urandom_range(0, 9) < 3) begin
            it.vehicle_speed = 16'($urandom);
        end else begin
            it.vehicle_speed = 16'(int'($urandom_range(0, 4096)) - 2048);
        end
        it.shift_up = $urandom_range(0, 4) == 0;
        it.shift_down = $urandom_range(0, 5) == 0;
        it.restart = $urandom_range(0, 29) == 0;
        return it;
    endfunction

    function automatic logic [15:0] rand_rate();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 4096));
            2: return 16'($urandom_range(4096, 32768));
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (err_count < 40) begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        end
        err_count++;
    endtask

    task automatic write_reg(logic [2:0] addr, logic [15:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        case (addr)
            dsl_pkg::REG_PEDAL_RATE:        pedal_rate_q = value;
            dsl_pkg::REG_STEER_RATE:        steer_rate_q = value;
            dsl_pkg::REG_STEER_RETURN_RATE: return_rate_q = value;
            dsl_pkg::REG_MAX_STEER:         max_steer_q = value[14:0];
            dsl_pkg::REG_STEER_FALLOFF:     falloff_q = value;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [15:0] pedal, logic [15:0] steer, logic [15:0] ret,
                                  logic [15:0] max_steer, logic [15:0] falloff);
        write_reg(dsl_pkg::REG_PEDAL_RATE, pedal);
        write_reg(dsl_pkg::REG_STEER_RATE, steer);
        write_reg(dsl_pkg::REG_STEER_RETURN_RATE, ret);
        write_reg(dsl_pkg::REG_MAX_STEER, max_steer);
        write_reg(dsl_pkg::REG_STEER_FALLOFF, falloff);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_controls.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                expected_controls.push_back(advance_controls(drv_tick));
                if (jitter_on && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 8);
                end
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    drv_tick <= pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_controls got;
        t_controls want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got = o_m_axis_tdata[$bits(t_controls)-1:0];
                if (expected_controls.size() == 0) begin
                    flag_mismatch("unexpected item, tdata low word", int'(got[31:0]), 0);
                end else begin
                    want = expected_controls.pop_front();
                    if (got.throttle_level !== want.throttle_level)
                        flag_mismatch("throttle_level", got.throttle_level, want.throttle_level);
                    if (got.brake_level !== want.brake_level)
                        flag_mismatch("brake_level", got.brake_level, want.brake_level);
                    if (got.clutch_engagement !== want.clutch_engagement)
                        flag_mismatch("clutch_engagement", got.clutch_engagement,
                                      want.clutch_engagement);
                    if (got.handbrake_level !== want.handbrake_level)
                        flag_mismatch("handbrake_level", got.handbrake_level,
                                      want.handbrake_level);
                    if (got.steer_angle !== want.steer_angle)
                        flag_mismatch("steer_angle", int'(got.steer_angle),
                                      int'(want.steer_angle));
                    if (got.steer_limit !== want.steer_limit)
                        flag_mismatch("steer_limit", got.steer_limit, want.steer_limit);
                    if (got.gear !== want.gear)
                        flag_mismatch("gear", got.gear, want.gear);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: pedal extremes, gear saturation, restart
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(65535, 8191, -8192, 8191, -8192, 8191, 32767,
                                          1, 0, 0));
        pending_ticks.push_back(make_tick(65535, -8192, 8191, -8192, 8191, -8192, -32768,
                                          1, 0, 0));
        pending_ticks.push_back(make_tick(1, 4096, 4096, -4096, 4096, 4096, 0, 1, 0, 0));
        pending_ticks.push_back(make_tick(32768, 4097, -1, 0, 4097, -1, -1, 1, 0, 0));
        pending_ticks.push_back(make_tick(100, 4095, 1, 1, 1, 4095, 1, 1, 1, 0));
        for (int i = 0; i < 4; i++) begin
            pending_ticks.push_back(make_tick(2000, 2048, 1024, 0, 2048, 0, 256, 0, 1, 0));
        end
        pending_ticks.push_back(make_tick(65535, 4096, 4096, 4096, 0, 0, 0, 1, 0, 1));
        wait_drained();

        // full steering range, upper bit of max_steer dropped
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        pending_ticks.push_back(make_tick(65535, 0, 0, 8191, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(65535, 0, 0, -8192, 0, 0, -32768, 0, 0, 0));
        pending_ticks.push_back(make_tick(1000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, 0, 0, 4096, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(65535, 0, 0, -4096, 0, 0, 32767, 1, 1, 0));
        pending_ticks.push_back(make_tick(300, 100, 100, 2000, 0, 0, 0, 1, 0, 1));
        wait_drained();
        write_reg(dsl_pkg::REG_STEER_FALLOFF, 16'hFFFF);
        pending_ticks.push_back(make_tick(65535, 0, 0, 4096, 0, 0, -32768, 0, 0, 0));
        pending_ticks.push_back(make_tick(65535, 0, 0, -4096, 0, 0, 32767, 0, 0, 0));
        pending_ticks.push_back(make_tick(500, 0, 0, 100, 0, 0, 1, 0, 0, 0));
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
                1: begin
                    apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                    write_reg(REG_SPARE_LO, 16'($urandom));
                    write_reg(REG_SPARE_HI, 16'hFFFF);
                end
                default: apply_settings(rand_rate(), rand_rate(), rand_rate(),
                                        16'($urandom_range(0, 32767)),
                                        $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                                  : 16'($urandom_range(0, 2048)));
            endcase
            if (phase == 5) begin
                jitter_on = 1'b0;
            end
            for (int i = 0; i < 300; i++) begin
                pending_ticks.push_back(rand_tick());
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (err_count == 0 && expected_controls.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
